@@ design/nsgi_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nsgi_pkg: shared types and constants for the next-smaller/greater index core
// Field widths, configuration register indexes, parameter defaults and the
// command word that steers the stack cell chain.
// ----------------------------------------------------------------------------
package nsgi_pkg;

	localparam int POS_WIDTH       = 8;
	localparam int RANK_IN_WIDTH   = 16;
	localparam int NEXT_IDX_WIDTH  = 9;
	localparam int CFG_DATA_WIDTH  = 9;
	localparam int CFG_INDEX_WIDTH = 1;

	localparam int DEFAULT_MAX_LENGTH = 256;
	localparam int DEFAULT_RANK_WIDTH = 16;

	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_IDX_FIND_SMALLER = 1'b0;
	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_IDX_SEQ_LENGTH   = 1'b1;

	localparam logic                      FIND_SMALLER_RESET = 1'b1;
	localparam logic [NEXT_IDX_WIDTH-1:0] SEQ_LENGTH_RESET   = 9'd256;

	// One command per cycle for every cell; clear wins over push, push over pop.
	typedef struct packed {
		logic clear;
		logic push;
		logic pop;
	} cell_cmd_t;

endpackage
`default_nettype wire

@@ design/nsgi_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nsgi_cell: one slot of the shifting stack
// Holds one (position, rank) entry; takes the upper neighbor's entry on a
// push and the lower neighbor's entry on a pop.
// ----------------------------------------------------------------------------
module nsgi_cell #(
	parameter int RANK_WIDTH = nsgi_pkg::DEFAULT_RANK_WIDTH
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire nsgi_pkg::cell_cmd_t          cmd,
	input  wire                               up_valid,
	input  wire [nsgi_pkg::POS_WIDTH-1:0]     up_pos,
	input  wire [RANK_WIDTH-1:0]              up_rank,
	input  wire                               dn_valid,
	input  wire [nsgi_pkg::POS_WIDTH-1:0]     dn_pos,
	input  wire [RANK_WIDTH-1:0]              dn_rank,
	output logic                              valid,
	output logic [nsgi_pkg::POS_WIDTH-1:0]    pos,
	output logic [RANK_WIDTH-1:0]             rank
);

	logic                           valid_q;
	logic [nsgi_pkg::POS_WIDTH-1:0] pos_q;
	logic [RANK_WIDTH-1:0]          rank_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.clear) begin
			valid_q <= 1'b0;
		end else if (cmd.push) begin
			valid_q <= up_valid;
		end else if (cmd.pop) begin
			valid_q <= dn_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			pos_q  <= up_pos;
			rank_q <= up_rank;
		end else if (cmd.pop) begin
			pos_q  <= dn_pos;
			rank_q <= dn_rank;
		end
	end

	assign valid = valid_q;
	assign pos   = pos_q;
	assign rank  = rank_q;

endmodule
`default_nettype wire

@@ design/next_smaller_or_greater_index_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// next_smaller_or_greater_index_core: nearest later index with smaller/greater rank
// Monotonic stack built as a chain of shifting cells, top of stack in cell 0.
// ----------------------------------------------------------------------------
// Feed ranks from the last position of a sequence to the first; each input
// beat gives one output beat with the nearest later position whose rank is
// strictly smaller (find_smaller = 1) or strictly greater (find_smaller = 0),
// or sequence_length when there is none. The stack lives in MAX_LENGTH cells
// that shift as one: a pop moves every entry one cell toward the top, a push
// one cell away from it, so only cell 0 is ever compared. An item first pops
// every entry it discards, one pop per cycle through the chain, and is then
// pushed once no pop is due and the output register is free; every entry is
// popped at most once. The next item is taken in the same cycle as the
// current one is pushed, and the output register lets it start while the
// previous result is still held by out_stall. begin_sequence clears every
// cell at once when its beat is taken. A push onto a full chain is dropped
// and flagged in overflow. Write configuration only while idle.
// ----------------------------------------------------------------------------
module next_smaller_or_greater_index_core #(
	parameter int MAX_LENGTH = nsgi_pkg::DEFAULT_MAX_LENGTH,
	parameter int RANK_WIDTH = nsgi_pkg::DEFAULT_RANK_WIDTH
) (
	input  wire                                    clk,
	input  wire                                    arst_n,
	// configuration
	input  wire                                    cfg_write_en,
	input  wire [nsgi_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
	input  wire [nsgi_pkg::CFG_DATA_WIDTH-1:0]     cfg_data,
	// input channel
	input  wire                                    in_valid,
	output logic                                   in_stall,
	input  wire [nsgi_pkg::POS_WIDTH-1:0]          position,
	input  wire [nsgi_pkg::RANK_IN_WIDTH-1:0]      rank_value,
	input  wire                                    begin_sequence,
	// output channel
	output logic                                   out_valid,
	input  wire                                    out_stall,
	output logic [nsgi_pkg::POS_WIDTH-1:0]         result_position,
	output logic [nsgi_pkg::NEXT_IDX_WIDTH-1:0]    next_index,
	output logic                                   overflow
);

	// Configuration registers
	logic                                  find_smaller_q;
	logic [nsgi_pkg::NEXT_IDX_WIDTH-1:0]   seq_length_q;

	// Item in flight
	logic                                  busy_q;
	logic [nsgi_pkg::POS_WIDTH-1:0]        item_pos_q;
	logic [RANK_WIDTH-1:0]                 item_rank_q;
	logic [RANK_WIDTH-1:0]                 item_rank_d;

	// Output register
	logic                                  out_valid_q;
	logic [nsgi_pkg::POS_WIDTH-1:0]        res_pos_q;
	logic [nsgi_pkg::NEXT_IDX_WIDTH-1:0]   res_next_q;
	logic                                  res_ovf_q;

	// Cell chain
	logic [MAX_LENGTH-1:0]                 cell_valid;
	logic [nsgi_pkg::POS_WIDTH-1:0]        cell_pos  [MAX_LENGTH];
	logic [RANK_WIDTH-1:0]                 cell_rank [MAX_LENGTH];
	nsgi_pkg::cell_cmd_t                   cmd;

	logic in_fire;
	logic out_free;
	logic discard_top;
	logic pop_now;
	logic push_fire;
	logic stack_full;

	// Compare on the low RANK_WIDTH bits of the rank, zero-extended if wider.
	generate
		if (RANK_WIDTH <= nsgi_pkg::RANK_IN_WIDTH) begin : g_rank_trunc
			assign item_rank_d = rank_value[RANK_WIDTH-1:0];
		end else begin : g_rank_ext
			assign item_rank_d = {{(RANK_WIDTH - nsgi_pkg::RANK_IN_WIDTH){1'b0}}, rank_value};
		end
	endgenerate

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			find_smaller_q <= nsgi_pkg::FIND_SMALLER_RESET;
			seq_length_q   <= nsgi_pkg::SEQ_LENGTH_RESET;
		end else if (cfg_write_en) begin
			unique case (cfg_index)
				nsgi_pkg::CFG_IDX_FIND_SMALLER: find_smaller_q <= cfg_data[0];
				nsgi_pkg::CFG_IDX_SEQ_LENGTH:   seq_length_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Top entry goes if the mode condition discards it
	assign discard_top = find_smaller_q ? (cell_rank[0] >= item_rank_q)
	                                    : (cell_rank[0] <= item_rank_q);

	assign out_free   = !out_valid_q || !out_stall;
	assign pop_now    = busy_q && cell_valid[0] && discard_top;
	assign push_fire  = busy_q && !pop_now && out_free;
	assign stack_full = cell_valid[MAX_LENGTH-1];

	// Take a beat while idle, or in the cycle the current item finishes
	assign in_stall = busy_q && !push_fire;
	assign in_fire  = in_valid && !in_stall;

	// A begin beat clears the whole chain; that also wipes a push of the same edge,
	// which belongs to the sequence that just ended.
	always_comb begin
		cmd.clear = in_fire && begin_sequence;
		cmd.push  = push_fire && !stack_full;
		cmd.pop   = pop_now;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (in_fire) begin
			busy_q <= 1'b1;
		end else if (push_fire) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			item_pos_q  <= position;
			item_rank_q <= item_rank_d;
		end
	end

	// Result: hold while stalled, load when the item is pushed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push_fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push_fire) begin
			res_pos_q  <= item_pos_q;
			res_next_q <= cell_valid[0] ? {1'b0, cell_pos[0]} : seq_length_q;
			res_ovf_q  <= stack_full;
		end
	end

	assign out_valid       = out_valid_q;
	assign result_position = res_pos_q;
	assign next_index      = res_next_q;
	assign overflow        = res_ovf_q;

	// Chain of cells: cell 0 is the top, the new item enters there on a push,
	// and an empty slot enters the bottom on a pop.
	generate
		for (genvar i = 0; i < MAX_LENGTH; i++) begin : g_cell
			logic                           up_valid;
			logic [nsgi_pkg::POS_WIDTH-1:0] up_pos;
			logic [RANK_WIDTH-1:0]          up_rank;
			logic                           dn_valid;
			logic [nsgi_pkg::POS_WIDTH-1:0] dn_pos;
			logic [RANK_WIDTH-1:0]          dn_rank;

			if (i == 0) begin : g_top
				assign up_valid = 1'b1;
				assign up_pos   = item_pos_q;
				assign up_rank  = item_rank_q;
			end else begin : g_mid_up
				assign up_valid = cell_valid[i-1];
				assign up_pos   = cell_pos[i-1];
				assign up_rank  = cell_rank[i-1];
			end

			if (i == MAX_LENGTH - 1) begin : g_bottom
				assign dn_valid = 1'b0;
				assign dn_pos   = '0;
				assign dn_rank  = '0;
			end else begin : g_mid_dn
				assign dn_valid = cell_valid[i+1];
				assign dn_pos   = cell_pos[i+1];
				assign dn_rank  = cell_rank[i+1];
			end

			nsgi_cell #(
				.RANK_WIDTH (RANK_WIDTH)
			) u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.cmd      (cmd),
				.up_valid (up_valid),
				.up_pos   (up_pos),
				.up_rank  (up_rank),
				.dn_valid (dn_valid),
				.dn_pos   (dn_pos),
				.dn_rank  (dn_rank),
				.valid    (cell_valid[i]),
				.pos      (cell_pos[i]),
				.rank     (cell_rank[i])
			);
		end
	endgenerate

endmodule
`default_nettype wire

@@ design/nsgi_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nsgi_checker: port-level checks for the next-smaller/greater index core
// Watches the handshakes and the ordering between input and output beats.
// ----------------------------------------------------------------------------
module nsgi_checker (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 in_stall,
	input  wire                                 out_valid,
	input  wire                                 out_stall,
	input  wire [nsgi_pkg::POS_WIDTH-1:0]       result_position,
	input  wire [nsgi_pkg::NEXT_IDX_WIDTH-1:0]  next_index,
	input  wire                                 overflow
);

	// A stalled result beat stays
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("output beat dropped while stalled");

	// A stalled result beat keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(result_position) && $stable(next_index)
			&& $stable(overflow))
		else $error("output payload changed while stalled");

	// A new result is loaded only in the cycle an item finishes, which also frees the input
	a_result_frees_input: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_stall))
		else $error("result appeared without the input side being released");

	// A busy item cannot finish while the held result stays blocked
	a_blocked_holds_input: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall && in_stall ##1 out_stall |-> in_stall)
		else $error("input released while previous result still blocked");

endmodule

bind next_smaller_or_greater_index_core nsgi_checker u_nsgi_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_stall        (in_stall),
	.out_valid       (out_valid),
	.out_stall       (out_stall),
	.result_position (result_position),
	.next_index      (next_index),
	.overflow        (overflow)
);
`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for next_smaller_or_greater_index_core
// Drives rank beats through the valid/stall input channel, predicts every
// result beat with a local monotonic stack, and compares each accepted result
// field by field. Directed tests cover reset defaults, both modes, ties,
// extreme ranks, odd register values, a full stack and a long receiver
// hold-off; random phases send well-formed sequences mixed with noise under
// random idling.
// ----------------------------------------------------------------------------
module testbench;

	localparam int POS_WIDTH       = nsgi_pkg::POS_WIDTH;
	localparam int RANK_IN_WIDTH   = nsgi_pkg::RANK_IN_WIDTH;
	localparam int NEXT_IDX_WIDTH  = nsgi_pkg::NEXT_IDX_WIDTH;
	localparam int CFG_DATA_WIDTH  = nsgi_pkg::CFG_DATA_WIDTH;
	localparam int CFG_INDEX_WIDTH = nsgi_pkg::CFG_INDEX_WIDTH;

	localparam int MAX_LENGTH      = nsgi_pkg::DEFAULT_MAX_LENGTH;
	localparam int IDLE_PCT        = 22;
	localparam int HOLD_OFF_CYCLES = 300;
	// Watchdog limit on a busy stretch with no beat on either channel.
	localparam int STALL_LIMIT     = 4000;
	localparam int END_WAIT        = 16;
	localparam int RANDOM_ITEMS    = 1150;

	typedef struct packed {
		logic [POS_WIDTH-1:0]      pos;
		logic [NEXT_IDX_WIDTH-1:0] next;
		logic                      ovf;
	} answer_t;

	typedef enum int {
		RANK_ANY,
		RANK_NARROW,
		RANK_EXTREME,
		RANK_RISING,
		RANK_FALLING
	} rank_style_e;

	// Clock, reset and every block input start at a known value.
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_write_en = 1'b0;
	logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
	logic [CFG_DATA_WIDTH-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [POS_WIDTH-1:0] position = '0;
	logic [RANK_IN_WIDTH-1:0] rank_value = '0;
	logic begin_sequence = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [POS_WIDTH-1:0] result_position;
	logic [NEXT_IDX_WIDTH-1:0] next_index;
	logic overflow;

	// Shadow of the block: stack, mode and length as the block should hold them.
	logic [POS_WIDTH-1:0]     stk_pos [MAX_LENGTH];
	logic [RANK_IN_WIDTH-1:0] stk_rank [MAX_LENGTH];
	int                       stack_depth = 0;
	logic                     mode_smaller = nsgi_pkg::FIND_SMALLER_RESET;
	logic [NEXT_IDX_WIDTH-1:0] seq_length = nsgi_pkg::SEQ_LENGTH_RESET;

	answer_t pending_answers[$];
	int error_count = 0;
	int random_items = 0;
	int hold_requests = 0;
	logic no_idle = 1'b0;

	next_smaller_or_greater_index_core DUT (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_write_en    (cfg_write_en),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.position        (position),
		.rank_value      (rank_value),
		.begin_sequence  (begin_sequence),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.result_position (result_position),
		.next_index      (next_index),
		.overflow        (overflow)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Apply one accepted beat to the shadow stack and return the answer it owes.
	function automatic answer_t advance_stack(input logic [POS_WIDTH-1:0] p,
			input logic [RANK_IN_WIDTH-1:0] r, input logic b);
		answer_t a;
		if (b)
			stack_depth = 0;
		// Drop every top entry the mode discards; ties are always discarded.
		while (stack_depth > 0 && (mode_smaller ? (stk_rank[stack_depth-1] >= r)
				: (stk_rank[stack_depth-1] <= r)))
			stack_depth--;
		a.pos = p;
		a.next = (stack_depth > 0) ? {1'b0, stk_pos[stack_depth-1]} : seq_length;
		a.ovf = 1'b0;
		if (stack_depth < MAX_LENGTH) begin
			stk_pos[stack_depth] = p;
			stk_rank[stack_depth] = r;
			stack_depth++;
		end else begin
			// Full stack: answer still given, push dropped.
			a.ovf = 1'b1;
		end
		return a;
	endfunction

	function automatic logic [RANK_IN_WIDTH-1:0] pick_rank(input rank_style_e style,
			input logic [RANK_IN_WIDTH-1:0] prev);
		case (style)
			RANK_ANY: return RANK_IN_WIDTH'($urandom);
			RANK_NARROW: return RANK_IN_WIDTH'($urandom_range(3));
			RANK_EXTREME: return $urandom_range(1) ? '1 : '0;
			RANK_RISING: begin
				if (prev > 16'd65000)
					return prev;
				return prev + RANK_IN_WIDTH'($urandom_range(300));
			end
			default: begin
				if (prev < 16'd600)
					return prev;
				return prev - RANK_IN_WIDTH'($urandom_range(300));
			end
		endcase
	endfunction

	task automatic report_mismatch(input string what, input int unsigned got,
			input int unsigned want_v);
		$display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want_v, $time);
		error_count++;
	endtask

	// Offer one beat, hold it until taken, then record the answer it owes.
	// Valid stays high afterwards so back-to-back beats need no extra edge.
	task automatic send_item(input logic [POS_WIDTH-1:0] p,
			input logic [RANK_IN_WIDTH-1:0] r, input logic b);
		answer_t owed;
		while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		position <= p;
		rank_value <= r;
		begin_sequence <= b;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		owed = advance_stack(p, r, b);
		pending_answers = {pending_answers, owed};
	endtask

	// Drop valid and wait until every owed answer has come back.
	task automatic drain;
		in_valid <= 1'b0;
		while (pending_answers.size() != 0)
			@(posedge clk);
	endtask

	// Write both registers; only called with the block idle.
	task automatic set_mode_and_length(input logic smaller,
			input logic [CFG_DATA_WIDTH-1:0] len);
		cfg_write_en <= 1'b1;
		cfg_index <= nsgi_pkg::CFG_IDX_FIND_SMALLER;
		// Upper data bits are don't-care for the one-bit mode register.
		cfg_data <= {(CFG_DATA_WIDTH-1)'($urandom), smaller};
		@(posedge clk);
		mode_smaller = smaller;
		cfg_index <= nsgi_pkg::CFG_IDX_SEQ_LENGTH;
		cfg_data <= len;
		@(posedge clk);
		seq_length = len;
		cfg_write_en <= 1'b0;
	endtask

	// Reset values: smaller mode, length 256; ties, extremes, a mid-run begin
	// and positions that go back up.
	task automatic test_reset_defaults;
		send_item(8'd255, 16'd100, 1'b1);
		send_item(8'd254, 16'hFFFF, 1'b0);
		send_item(8'd253, 16'hFFFF, 1'b0);
		send_item(8'd252, 16'd0, 1'b0);
		send_item(8'd251, 16'd0, 1'b0);
		send_item(8'd250, 16'd1, 1'b0);
		send_item(8'd5, 16'd7, 1'b1);
		send_item(8'd0, 16'd3, 1'b0);
		send_item(8'd200, 16'd2, 1'b0);
		drain();
	endtask

	task automatic test_greater_mode;
		set_mode_and_length(1'b0, 9'd8);
		send_item(8'd7, 16'd5, 1'b1);
		send_item(8'd6, 16'd5, 1'b0);
		send_item(8'd5, 16'd9, 1'b0);
		send_item(8'd4, 16'd0, 1'b0);
		send_item(8'd3, 16'hFFFF, 1'b0);
		send_item(8'd2, 16'hFFFF, 1'b0);
		send_item(8'd1, 16'd3, 1'b0);
		send_item(8'd0, 16'd0, 1'b0);
		drain();
	endtask

	// Shortest legal length, then values outside the legal range as they are.
	task automatic test_length_extremes;
		set_mode_and_length(1'b1, 9'd1);
		send_item(8'd0, 16'd42, 1'b1);
		drain();
		set_mode_and_length(1'b1, 9'd0);
		send_item(8'd3, 16'd10, 1'b1);
		send_item(8'd2, 16'd10, 1'b0);
		drain();
		set_mode_and_length(1'b0, 9'd511);
		send_item(8'd1, 16'd0, 1'b1);
		send_item(8'd0, 16'hFFFF, 1'b0);
		drain();
	endtask

	// Fill the stack past its depth in each mode, then pop the whole chain
	// with one beat. The greater-mode pass runs with no idling on either side.
	task automatic test_overflow;
		set_mode_and_length(1'b1, 9'd256);
		for (int i = 0; i < MAX_LENGTH + 2; i++)
			send_item(POS_WIDTH'(255 - i), RANK_IN_WIDTH'(i * 200), i == 0);
		send_item(8'd0, 16'd0, 1'b0);
		drain();
		no_idle <= 1'b1;
		set_mode_and_length(1'b0, 9'd256);
		for (int i = 0; i < MAX_LENGTH + 2; i++)
			send_item(POS_WIDTH'(255 - i), RANK_IN_WIDTH'(65535 - i * 200), i == 0);
		send_item(8'd0, 16'hFFFF, 1'b0);
		drain();
		no_idle <= 1'b0;
	endtask

	// Receiver holds off for a long stretch while beats keep coming, so the
	// block backs up and stalls its input.
	task automatic test_hold_off;
		logic [RANK_IN_WIDTH-1:0] r;
		r = 16'd10;
		set_mode_and_length(1'b1, 9'd40);
		hold_requests <= hold_requests + 1;
		for (int i = 0; i < 40; i++) begin
			r = pick_rank(RANK_RISING, r);
			send_item(POS_WIDTH'(39 - i), r, i == 0);
		end
		drain();
	endtask

	// Random phases: pick mode and length, send a few well-formed sequences
	// with random content, sprinkle in noise and broken beats.
	task automatic test_random_sequences;
		logic smaller;
		logic [CFG_DATA_WIDTH-1:0] len_reg;
		int seq_size;
		int n_seq;
		int pick;
		rank_style_e style;
		logic [RANK_IN_WIDTH-1:0] r;
		logic [POS_WIDTH-1:0] p;
		logic b;
		while (random_items < RANDOM_ITEMS) begin
			smaller = 1'($urandom_range(1));
			pick = $urandom_range(99);
			// Mostly short sequences, a few long ones up to the full depth.
			if (pick < 70)
				seq_size = $urandom_range(12, 1);
			else if (pick < 90)
				seq_size = $urandom_range(64, 13);
			else if (pick < 97)
				seq_size = $urandom_range(256, 65);
			else
				seq_size = $urandom_range(16, 1);
			if (pick >= 97)
				len_reg = $urandom_range(1) ? 9'd0 : CFG_DATA_WIDTH'($urandom_range(511, 257));
			else
				len_reg = CFG_DATA_WIDTH'(seq_size);
			set_mode_and_length(smaller, len_reg);
			n_seq = $urandom_range(3, 1);
			for (int s = 0; s < n_seq; s++) begin
				style = rank_style_e'($urandom_range(RANK_FALLING, RANK_ANY));
				r = RANK_IN_WIDTH'($urandom);
				for (int k = 0; k < seq_size; k++) begin
					pick = $urandom_range(99);
					r = pick_rank(style, r);
					p = POS_WIDTH'(seq_size - 1 - k);
					b = (k == 0);
					if (pick < 8) begin
						// noise: any field, any value
						p = POS_WIDTH'($urandom);
						r = RANK_IN_WIDTH'($urandom);
						b = 1'($urandom_range(1));
					end else if (pick < 12) begin
						// broken sequence: stray position or a begin out of place
						p = POS_WIDTH'($urandom);
						b = $urandom_range(3) == 0;
					end
					send_item(p, r, b);
					random_items++;
				end
			end
			drain();
		end
	endtask

	task automatic finish_run;
		while (pending_answers.size() != 0)
			@(posedge clk);
		repeat (END_WAIT) @(posedge clk);
		while (pending_answers.size() != 0) begin
			report_mismatch("result never arrived for position",
				32'(pending_answers[0].pos), 32'(pending_answers[0].pos));
			void'(pending_answers.pop_front());
		end
		if (error_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	endtask

	// Receiver: random stalls, a quiet stretch while no_idle is set, and a
	// counted hold-off whenever the test asks for one.
	initial begin : result_sink
		int hold_left;
		int hold_seen;
		hold_left = 0;
		hold_seen = 0;
		forever begin
			@(posedge clk);
			if (hold_requests != hold_seen) begin
				hold_seen = hold_requests;
				hold_left = HOLD_OFF_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= !no_idle && ($urandom_range(99) < IDLE_PCT);
			end
		end
	end

	// Compare every accepted result beat with the oldest owed answer.
	always @(posedge clk) begin
		answer_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_answers.size() == 0) begin
				report_mismatch("result beat with nothing owed, position",
					32'(result_position), 0);
			end else begin
				want = pending_answers.pop_front();
				if (result_position !== want.pos)
					report_mismatch("result_position", 32'(result_position), 32'(want.pos));
				if (next_index !== want.next)
					report_mismatch("next_index", 32'(next_index), 32'(want.next));
				if (overflow !== want.ovf)
					report_mismatch("overflow", 32'(overflow), 32'(want.ovf));
			end
		end
	end

	// Watchdog: count busy cycles with no beat on either channel.
	always @(posedge clk) begin : watchdog
		int quiet;
		if ((in_valid && !in_stall) || (out_valid && !out_stall)
				|| (pending_answers.size() == 0 && !in_valid))
			quiet = 0;
		else
			quiet++;
		if (quiet >= STALL_LIMIT) begin
			$display("TIMEOUT: no beat for %0d cycles at %0t", quiet, $time);
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		// Hold reset from the start, release it on an edge, never again.
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_greater_mode();
		test_length_extremes();
		test_overflow();
		test_hold_off();
		test_random_sequences();
		finish_run();
	end

endmodule

@@ filelist.f @@
design/nsgi_pkg.sv
design/nsgi_cell.sv
design/next_smaller_or_greater_index_core.sv
design/nsgi_checker.sv
tb/testbench.sv
